@@ hdl/smu_pkg.sv @@
// Shared types and constants for the serial mouse port block.
// Depends on nothing; the cell, chain, top level and checker take names from here.
`default_nettype none

package smu_pkg;

    // Default shift queue depth
    localparam int FIFO_DEPTH_DEF = 16;

    // Request opcodes
    typedef enum logic [2:0] {
        OP_PORT_WR  = 3'd0,
        OP_PORT_RD  = 3'd1,
        OP_BTN_DOWN = 3'd2,
        OP_BTN_UP   = 3'd3,
        OP_MOVE     = 3'd4
    } op_t;

    // Port offsets with special behavior
    localparam logic [2:0] PORT_DATA = 3'd0;
    localparam logic [2:0] PORT_MCR  = 3'd4;
    localparam logic [2:0] PORT_LSR  = 3'd5;

    // Packet and identification constants
    localparam logic [7:0] ID_BYTE   = 8'h4D;
    localparam int         ID_COUNT  = 6;
    localparam int         PKT_LEN   = 3;
    localparam logic [1:0] SYNC_BITS = 2'b01;
    localparam logic [7:0] LSR_VALUE = 8'h01;

    // Broadcast command to every queue cell
    typedef struct packed {
        logic       shift;
        logic       push;
        logic       ident;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
    } cell_ctl_t;

endpackage

`default_nettype wire

@@ hdl/smu_if.sv @@
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing; field widths are fixed here.
`default_nettype none

interface smu_req_if;
    logic              valid;
    logic              ready;
    logic [2:0]        op;
    logic [2:0]        port;
    logic [7:0]        wdata;
    logic              button;
    logic signed [7:0] dx;
    logic signed [7:0] dy;

    modport source (output valid, output op, output port, output wdata,
                    output button, output dx, output dy, input ready);
    modport sink   (input valid, input op, input port, input wdata,
                    input button, input dx, input dy, output ready);
endinterface

interface smu_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       irq_pulse;

    modport source (output valid, output read_data, output irq_pulse, input ready);
    modport sink   (input valid, input read_data, input irq_pulse, output ready);
endinterface

`default_nettype wire

@@ hdl/smu_cell.sv @@
// One entry of the shift queue: loads, shifts from its neighbor, or holds.
// Depends on smu_pkg (cell_ctl_t, ID_BYTE, ID_COUNT).
`default_nettype none

module smu_cell #(
    parameter int DEPTH = smu_pkg::FIFO_DEPTH_DEF,
    parameter int IDX   = 0,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  smu_pkg::cell_ctl_t     ctl,
    input  wire [CW-1:0]           base,
    input  wire [7:0]              right_byte,
    output logic [7:0]             data
);

    localparam logic [CW:0] IDX_C = (CW + 1)'(IDX);

    logic [7:0] data_reg;
    logic [7:0] data_next;
    logic [CW:0] rel;

    // Offset of this entry from the write position
    assign rel = IDX_C - {1'b0, base};

    // Select load, shift or hold
    always_comb
    begin
        data_next = data_reg;
        priority if (ctl.ident)
        begin
            if (IDX < smu_pkg::ID_COUNT)
                data_next = smu_pkg::ID_BYTE;
        end
        else if (ctl.push && rel == (CW + 1)'(0))
            data_next = ctl.byte0;
        else if (ctl.push && rel == (CW + 1)'(1))
            data_next = ctl.byte1;
        else if (ctl.push && rel == (CW + 1)'(2))
            data_next = ctl.byte2;
        else if (ctl.shift)
            data_next = right_byte;
        else
            data_next = data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            data_reg <= 8'h00;
        else
            data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

@@ hdl/smu_chain.sv @@
// Row of queue cells; entry 0 is the head, the last entry keeps its value on a shift.
// Depends on smu_pkg and smu_cell.
`default_nettype none

module smu_chain #(
    parameter int DEPTH = smu_pkg::FIFO_DEPTH_DEF,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  smu_pkg::cell_ctl_t     ctl,
    input  wire [CW-1:0]           base,
    output logic [7:0]             head
);

    logic [7:0] cell_data [DEPTH];

    // Wire each cell to its right neighbor
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [7:0] right;
        if (i == DEPTH - 1)
        begin : g_last
            assign right = cell_data[i];
        end
        else
        begin : g_mid
            assign right = cell_data[i + 1];
        end

        smu_cell #(
            .DEPTH (DEPTH),
            .IDX   (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .base       (base),
            .right_byte (right),
            .data       (cell_data[i])
        );
    end

    assign head = cell_data[0];

endmodule

`default_nettype wire

@@ hdl/serial_mouse_uart_model_top.sv @@
// Serial mouse behind an eight-port UART-style register window: top level.
// Depends on smu_pkg, smu_if and smu_chain.
//
// Takes one request per cycle and answers each with one response in the next
// cycle from an output register; a new request is taken while a response
// waits, as long as that response is taken in the same cycle. The whole
// update (register write, queue shift, identification refill or three-byte
// packet push) is applied at once, its queue part in the row of queue cells,
// so requests are sustained at one per clock with no refill or clearing pass.
`default_nettype none

module serial_mouse_uart_model_top #(
    parameter int FIFO_DEPTH = smu_pkg::FIFO_DEPTH_DEF,
    localparam int CW        = $clog2(FIFO_DEPTH + 1)
) (
    input  wire            clk,
    input  wire            rst_n,
    smu_req_if.sink        req_ch,
    smu_rsp_if.source      rsp_ch
);

    logic [7:0]    port_regs_reg [8];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [1:0]    btn_reg;
    logic [1:0]    btn_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [7:0]    rdata_reg;
    logic [7:0]    rdata_next;
    logic          irq_reg;
    logic          irq_next;

    logic               accept;
    smu_pkg::op_t       op;
    smu_pkg::cell_ctl_t ctl;
    logic [7:0]         head;
    logic [1:0]         mask;
    logic [7:0]         mcr_old;
    logic               mcr_toggle;
    logic [CW:0]        count_add;

    assign accept         = req_ch.valid && req_ch.ready;
    assign req_ch.ready   = !out_valid_reg || rsp_ch.ready;
    assign op             = smu_pkg::op_t'(req_ch.op);
    assign mask           = req_ch.button ? 2'b01 : 2'b10;
    assign mcr_old        = port_regs_reg[smu_pkg::PORT_MCR];
    assign mcr_toggle     = (req_ch.port == smu_pkg::PORT_MCR)
                            && (mcr_old[0] != req_ch.wdata[0]);
    assign count_add      = {1'b0, count_reg} + (CW + 1)'(smu_pkg::PKT_LEN);

    // Decode the request into button, queue and response updates
    always_comb
    begin
        btn_next   = btn_reg;
        count_next = count_reg;
        rdata_next = 8'h00;
        irq_next   = 1'b0;
        ctl        = '0;
        unique case (op)
            smu_pkg::OP_PORT_WR:
            begin
                if (mcr_toggle)
                begin
                    ctl.ident  = accept;
                    count_next = CW'(smu_pkg::ID_COUNT);
                    irq_next   = 1'b1;
                end
            end
            smu_pkg::OP_PORT_RD:
            begin
                if (req_ch.port == smu_pkg::PORT_DATA)
                begin
                    ctl.shift  = accept;
                    rdata_next = head;
                    if (count_reg != '0)
                        count_next = count_reg - CW'(1);
                    irq_next = count_reg > CW'(1);
                end
                else if (req_ch.port == smu_pkg::PORT_LSR)
                    rdata_next = smu_pkg::LSR_VALUE;
                else
                    rdata_next = port_regs_reg[req_ch.port];
            end
            smu_pkg::OP_BTN_DOWN, smu_pkg::OP_BTN_UP, smu_pkg::OP_MOVE:
            begin
                if (op == smu_pkg::OP_BTN_DOWN)
                    btn_next = btn_reg | mask;
                else if (op == smu_pkg::OP_BTN_UP)
                    btn_next = btn_reg & ~mask;
                ctl.push = accept;
                if (op == smu_pkg::OP_MOVE)
                begin
                    ctl.byte0 = {smu_pkg::SYNC_BITS, btn_next,
                                 req_ch.dy[7:6], req_ch.dx[7:6]};
                    ctl.byte1 = {2'b00, req_ch.dx[5:0]};
                    ctl.byte2 = {2'b00, req_ch.dy[5:0]};
                end
                else
                    ctl.byte0 = {smu_pkg::SYNC_BITS, btn_next, 4'b0000};
                if (count_add > (CW + 1)'(FIFO_DEPTH))
                    count_next = CW'(FIFO_DEPTH);
                else
                    count_next = count_add[CW-1:0];
                irq_next = count_reg == '0;
            end
            default:
            begin
                rdata_next = 8'h00;
            end
        endcase
    end

    // Hold the queue contents in the cell row
    smu_chain #(
        .DEPTH (FIFO_DEPTH)
    ) u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .base  (count_reg),
        .head  (head)
    );

    // Advance state on an accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            btn_reg   <= 2'b00;
            for (int i = 0; i < 8; i++)
                port_regs_reg[i] <= 8'h00;
        end
        else if (accept)
        begin
            count_reg <= count_next;
            btn_reg   <= btn_next;
            if (op == smu_pkg::OP_PORT_WR)
                port_regs_reg[req_ch.port] <= req_ch.wdata;
            else if (op == smu_pkg::OP_PORT_RD && req_ch.port == smu_pkg::PORT_DATA)
                port_regs_reg[smu_pkg::PORT_MCR] <= {7'b0000000, ~mcr_old[0]};
        end
    end

    // Hold the response until it is taken
    assign out_valid_next = accept ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg <= rdata_next;
            irq_reg   <= irq_next;
        end
    end

    assign rsp_ch.valid     = out_valid_reg;
    assign rsp_ch.read_data = rdata_reg;
    assign rsp_ch.irq_pulse = irq_reg;

endmodule

`default_nettype wire

@@ hdl/smu_checker.sv @@
// Port-level checks for the serial mouse block, bound to the top level.
// Depends on smu_pkg (opcodes, port offsets) and the top level's channel signals.
`default_nettype none

module smu_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       req_valid,
    input wire       req_ready,
    input wire [2:0] req_op,
    input wire [2:0] req_port,
    input wire       rsp_valid,
    input wire       rsp_ready,
    input wire [7:0] rsp_read_data,
    input wire       rsp_irq_pulse
);

    // Every accepted request yields a response in the next cycle
    a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> rsp_valid)
        else $error("no response after accepted request");

    // Never stall requests while the response slot is free
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request stalled with empty response slot");

    // Line status always reads one
    a_lsr_one: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req_op == smu_pkg::OP_PORT_RD
         && req_port == smu_pkg::PORT_LSR)
        |=> rsp_read_data == smu_pkg::LSR_VALUE)
        else $error("line status read not one");

    // Hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
        (rsp_valid && $stable(rsp_read_data) && $stable(rsp_irq_pulse)))
        else $error("stalled response changed");

endmodule

bind serial_mouse_uart_model_top smu_checker u_smu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req_ch.valid),
    .req_ready     (req_ch.ready),
    .req_op        (req_ch.op),
    .req_port      (req_ch.port),
    .rsp_valid     (rsp_ch.valid),
    .rsp_ready     (rsp_ch.ready),
    .rsp_read_data (rsp_ch.read_data),
    .rsp_irq_pulse (rsp_ch.irq_pulse)
);

`default_nettype wire
